### hdl/motor_power_limiter_top_defines.svh
// Assertion macros shared by the power limiter checkers.
`ifndef MOTOR_POWER_LIMITER_TOP_DEFINES_SVH
`define MOTOR_POWER_LIMITER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define MPL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("power limiter check failed");

// Next-cycle implication, off while reset is held.
`define MPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("power limiter check failed");

// Holds in the cycle after any reset cycle.
`define MPL_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("power limiter reset check failed");

`endif

### hdl/mpl_pkg.sv
package mpl_pkg;

    // Window and clamp settings.
    localparam int MOTORS_PER_WINDOW = 4;
    localparam int SLOT_W = (MOTORS_PER_WINDOW > 1) ? $clog2(MOTORS_PER_WINDOW) : 1;
    localparam logic signed [15:0] CURRENT_CLAMP = 16'sd16000;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHASSIS_LIMIT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SUPERCAP_EN = 1'b1;
    localparam logic [7:0] CHASSIS_LIMIT_RST = 8'd50;

    // Model coefficients, power terms scaled by 2^40.
    localparam logic signed [31:0] KT40 = 32'sd2195604;
    localparam logic signed [31:0] A40 = 32'sd135240;
    localparam logic signed [31:0] K2_40 = 32'sd159759;
    localparam logic signed [53:0] C40 = 54'sd4487106952954;
    localparam logic signed [31:0] HALF_RATIO_Q24 = 32'sd136188024;
    localparam logic signed [31:0] K2A_Q16 = 32'sd77418;
    localparam logic signed [57:0] CA_Q16 = 58'sd2174409886269;
    localparam logic signed [31:0] SA_Q8 = 32'sd2081300813;
    localparam logic [12:0] CAP_MAX_CW = 13'd5000;
    // floor(x/100) = (x * RECIP_100) >> 32 for x below 2^30.
    localparam logic signed [31:0] RECIP_100 = 32'sd42949673;

    // Iteration counts of the shift-subtract units.
    localparam int DIV_STEPS = 38;
    localparam int SQRT_STEPS = 28;
    localparam int CNT_W = 6;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CW, ST_KT, ST_WW, ST_K2, ST_CC, ST_A, ST_BUD, ST_PW, ST_WIN,
        ST_DECIDE, ST_DIVLD, ST_P, ST_Q, ST_PP, ST_DIV, ST_SQ, ST_DISC, ST_SQRT,
        ST_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CW, OP_KT, OP_WW, OP_K2, OP_CC, OP_A, OP_BUD, OP_PW,
        OP_WIN, OP_NUM, OP_DIVLD, OP_P, OP_Q, OP_PP, OP_DIVSTEP, OP_SQ, OP_DISC,
        OP_SQRTSTEP, OP_FIN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic need_scale;
        logic out_free;
    } t_status;

endpackage

### hdl/mpl_ctrl.sv
module mpl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mpl_pkg::t_status i_status,
    output mpl_pkg::t_cmd   o_cmd
);
    import mpl_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_CW;
            ST_CW:     n_state = ST_KT;
            ST_KT:     n_state = ST_WW;
            ST_WW:     n_state = ST_K2;
            ST_K2:     n_state = ST_CC;
            ST_CC:     n_state = ST_A;
            ST_A:      n_state = ST_BUD;
            ST_BUD:    n_state = ST_PW;
            ST_PW:     n_state = ST_WIN;
            ST_WIN:    n_state = ST_DECIDE;
            ST_DECIDE: n_state = i_status.need_scale ? ST_DIVLD : ST_FIN;
            ST_DIVLD: begin
                n_state = ST_P;
                n_cnt   = CNT_W'(DIV_STEPS - 1);
            end
            ST_P:      n_state = ST_Q;
            ST_Q:      n_state = ST_PP;
            ST_PP:     n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_SQ;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_SQ:     n_state = ST_DISC;
            ST_DISC: begin
                n_state = ST_SQRT;
                n_cnt   = CNT_W'(SQRT_STEPS - 1);
            end
            ST_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_FIN:    if (i_status.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            ST_CW:     o_cmd.op = OP_CW;
            ST_KT:     o_cmd.op = OP_KT;
            ST_WW:     o_cmd.op = OP_WW;
            ST_K2:     o_cmd.op = OP_K2;
            ST_CC:     o_cmd.op = OP_CC;
            ST_A:      o_cmd.op = OP_A;
            ST_BUD:    o_cmd.op = OP_BUD;
            ST_PW:     o_cmd.op = OP_PW;
            ST_WIN:    o_cmd.op = OP_WIN;
            ST_DECIDE: o_cmd.op = OP_NUM;
            ST_DIVLD:  o_cmd.op = OP_DIVLD;
            ST_P:      o_cmd.op = OP_P;
            ST_Q:      o_cmd.op = OP_Q;
            ST_PP:     o_cmd.op = OP_PP;
            ST_DIV:    o_cmd.op = OP_DIVSTEP;
            ST_SQ:     o_cmd.op = OP_SQ;
            ST_DISC:   o_cmd.op = OP_DISC;
            ST_SQRT:   o_cmd.op = OP_SQRTSTEP;
            ST_FIN:    if (i_status.out_free) o_cmd.op = OP_FIN;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

endmodule

### hdl/mpl_dp.sv
module mpl_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mpl_pkg::t_cmd                   i_cmd,
    output mpl_pkg::t_status                o_status,
    input  logic                            i_cfg_we,
    input  logic [mpl_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [mpl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic signed [15:0]              i_pid_current,
    input  logic signed [15:0]              i_motor_speed,
    input  logic [12:0]                     i_cap_power_centiwatt,
    input  logic                            i_cap_fault,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [15:0]              o_limited_current,
    output logic                            o_was_scaled
);
    import mpl_pkg::*;

    // Configuration and window state.
    logic [7:0]        r_limit;
    logic              r_cap_en;
    logic [31:0]       r_win_sum;
    logic [31:0]       r_last;
    logic [SLOT_W-1:0] r_slot;
    logic              r_out_valid;

    // Working registers of the current item.
    logic signed [15:0] r_cur, r_w;
    logic [12:0]        r_cap;
    logic               r_cap_on;
    logic signed [63:0] r_prod;
    logic signed [53:0] r_acc;
    logic [30:0]        r_ww;
    logic signed [21:0] r_pw;
    logic [16:0]        r_budget;
    logic               r_need;
    logic [37:0]        r_dnum;
    logic [31:0]        r_rem;
    logic signed [27:0] r_p;
    logic signed [57:0] r_q;
    logic signed [57:0] r_disc;
    logic [55:0]        r_rad;
    logic [29:0]        r_srem;
    logic [27:0]        r_root;
    logic signed [15:0] r_res;
    logic               r_scaled;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [20:0]        cap_term;
    logic signed [53:0] acc_rnd;
    logic [32:0]        sum_ext;
    logic [31:0]        sum_new;
    logic [SLOT_W:0]    slot_inc;
    logic signed [43:0] p_rnd;
    logic [32:0]        div_rem2;
    logic [32:0]        div_diff;
    logic signed [57:0] disc_full;
    logic [31:0]        sq_rem2;
    logic [31:0]        sq_trial;
    logic signed [29:0] i_q8;
    logic signed [29:0] i_rnd;
    logic signed [21:0] i_val;
    logic signed [15:0] i_clamped;

    // Supercap term numerator: clamped centiwatts * 256 + 50.
    assign cap_term = {r_cap, 8'd0} + 21'd50;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_CW:    begin mul_a = 32'(r_cur); mul_b = 32'(r_w); end
            OP_KT:    begin mul_a = KT40;       mul_b = r_prod[31:0]; end
            OP_WW:    begin mul_a = 32'(r_w);   mul_b = 32'(r_w); end
            OP_K2:    begin mul_a = K2_40;      mul_b = r_prod[31:0]; end
            OP_CC:    begin mul_a = 32'(r_cur); mul_b = 32'(r_cur); end
            OP_A:     begin mul_a = A40;        mul_b = r_prod[31:0]; end
            OP_BUD:   begin mul_a = {11'd0, cap_term}; mul_b = RECIP_100; end
            OP_NUM:   begin mul_a = 32'(r_pw);  mul_b = {15'd0, r_budget}; end
            OP_DIVLD: begin mul_a = 32'(r_w);   mul_b = HALF_RATIO_Q24; end
            OP_P:     begin mul_a = {1'b0, r_ww}; mul_b = K2A_Q16; end
            OP_Q:     begin mul_a = 32'(r_p);   mul_b = 32'(r_p); end
            OP_SQ:    begin mul_a = {11'd0, r_dnum[20:0]}; mul_b = SA_Q8; end
            default:  begin mul_a = '0;         mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Rounding, window and iteration step logic.
    assign acc_rnd   = (r_acc + 54'sd2147483648) >>> 32;
    assign sum_ext   = {1'b0, r_win_sum} + {11'd0, r_pw[20:0]};
    assign sum_new   = r_pw[21] ? r_win_sum : (sum_ext[32] ? '1 : sum_ext[31:0]);
    assign slot_inc  = {1'b0, r_slot} + 1'b1;
    assign p_rnd     = (r_prod[43:0] + 44'sd32768) >>> 16;
    assign div_rem2  = {r_rem, r_dnum[37]};
    assign div_diff  = div_rem2 - {1'b0, r_last};
    assign disc_full = r_disc + r_prod[57:0];
    assign sq_rem2   = {r_srem, r_rad[55:54]};
    assign sq_trial  = {2'b00, r_root, 2'b01};

    // Solved current: pick the root by command sign, round, clamp.
    always_comb begin
        if (!r_cur[15] && (r_cur != '0)) begin
            i_q8 = $signed({2'b00, r_root}) - 30'(r_p);
        end else begin
            i_q8 = -30'(r_p) - $signed({2'b00, r_root});
        end
        i_rnd = (i_q8 + 30'sd128) >>> 8;
        i_val = i_rnd[21:0];
        if (i_val > 22'(CURRENT_CLAMP)) begin
            i_clamped = CURRENT_CLAMP;
        end else if (i_val < -22'(CURRENT_CLAMP)) begin
            i_clamped = -CURRENT_CLAMP;
        end else begin
            i_clamped = i_val[15:0];
        end
    end

    // Control state: configuration, window and output flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= CHASSIS_LIMIT_RST;
            r_cap_en    <= 1'b0;
            r_win_sum   <= '0;
            r_last      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CHASSIS_LIMIT: r_limit  <= i_cfg_data;
                    CFG_SUPERCAP_EN:   r_cap_en <= i_cfg_data[0];
                    default:           r_limit  <= r_limit;
                endcase
            end
            if (i_cmd.op == OP_WIN) begin
                if (slot_inc >= (SLOT_W+1)'(MOTORS_PER_WINDOW)) begin
                    r_slot    <= '0;
                    r_last    <= sum_new;
                    r_win_sum <= '0;
                end else begin
                    r_slot    <= slot_inc[SLOT_W-1:0];
                    r_win_sum <= sum_new;
                end
            end
            if (i_cmd.op == OP_FIN) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic working registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (i_cmd.op)
            OP_LOAD: begin
                r_cur    <= i_pid_current;
                r_w      <= i_motor_speed;
                r_cap    <= (i_cap_power_centiwatt > CAP_MAX_CW) ? CAP_MAX_CW
                                                                 : i_cap_power_centiwatt;
                r_cap_on <= r_cap_en && !i_cap_fault;
            end
            OP_CW:  r_acc <= C40;
            OP_WW, OP_CC, OP_BUD: r_acc <= r_acc + r_prod[53:0];
            OP_K2:  r_ww <= r_prod[30:0];
            OP_PW: begin
                r_pw     <= acc_rnd[21:0];
                r_budget <= {1'b0, r_limit, 8'd0}
                            + (r_cap_on ? {3'd0, r_prod[45:32]} : 17'd0);
            end
            OP_NUM: begin
                r_need <= ({15'd0, r_budget} < r_last)
                          && !(r_pw[21] && (r_budget != '0));
            end
            OP_DIVLD: begin
                r_rem  <= '0;
                r_dnum <= r_prod[37:0] + {7'd0, r_last[31:1]};
            end
            OP_P:   r_p <= p_rnd[27:0];
            OP_Q:   r_q <= r_prod[57:0] + CA_Q16;
            OP_PP:  r_disc <= r_prod[57:0] - r_q;
            OP_DIVSTEP: begin
                if (!div_diff[32]) begin
                    r_rem  <= div_diff[31:0];
                    r_dnum <= {r_dnum[36:0], 1'b1};
                end else begin
                    r_rem  <= div_rem2[31:0];
                    r_dnum <= {r_dnum[36:0], 1'b0};
                end
            end
            OP_DISC: begin
                r_rad  <= disc_full[57] ? '0 : disc_full[55:0];
                r_root <= '0;
                r_srem <= '0;
            end
            OP_SQRTSTEP: begin
                r_rad <= {r_rad[53:0], 2'b00};
                if (sq_rem2 >= sq_trial) begin
                    r_srem <= 30'(sq_rem2 - sq_trial);
                    r_root <= {r_root[26:0], 1'b1};
                end else begin
                    r_srem <= sq_rem2[29:0];
                    r_root <= {r_root[26:0], 1'b0};
                end
            end
            OP_FIN: begin
                r_res    <= r_need ? i_clamped : r_cur;
                r_scaled <= r_need;
            end
            default: r_acc <= r_acc;
        endcase
    end

    assign o_status.need_scale = ({15'd0, r_budget} < r_last)
                                 && !(r_pw[21] && (r_budget != '0));
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_limited_current   = r_res;
    assign o_was_scaled        = r_scaled;

endmodule

### hdl/motor_power_limiter_top.sv
// Motor power limiter: one motor per input beat.
// Input beat (s_axis): commanded current, measured speed, supercap power
// and supercap fault. Output beat (m_axis): the limited current, with
// tuser high when the current was solved from the scaled power.
// Chassis limit and supercap enable are set through the write port
// (index 0 and 1); write them only while the block is idle (not enforced).
// Each beat runs on one shared 32x32 multiplier, a shift-subtract divider
// (38 steps) and a bit-pair square root (28 steps) under a sequencer.
// Output valid rises once the sequencer reaches its final step; a scaled
// beat first passes through the divider and square root steps, and the final
// step waits while a previous result is still held. A new beat is taken only
// after the current one has finished its sequence.
// The power sum runs over windows of four beats; the beat that closes a
// window is already compared with the new total.
// Reset sets the limit to 50 W, disables the supercap and clears the
// window. The result sits in an output register: a stalled receiver
// holds it, and a new beat is accepted meanwhile, but its result waits
// until the previous one is taken.
module motor_power_limiter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] pid_current, [31:16] motor_speed, [44:32] cap_power_centiwatt,
    // [45] cap_fault, [47:46] zero
    input  logic [47:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] limited_current
    output logic [15:0]                     m_axis_tdata,
    // [0] was_scaled
    output logic [0:0]                      m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [mpl_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [mpl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mpl_pkg::*;

    t_cmd               cmd;
    t_status            status;
    logic signed [15:0] limited_current;

    // Sequencer.
    mpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic and state.
    mpl_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_addr            (i_cfg_addr),
        .i_cfg_data            (i_cfg_data),
        .i_pid_current         (s_axis_tdata[15:0]),
        .i_motor_speed         (s_axis_tdata[31:16]),
        .i_cap_power_centiwatt (s_axis_tdata[44:32]),
        .i_cap_fault           (s_axis_tdata[45]),
        .o_out_valid           (m_axis_tvalid),
        .i_out_ready           (m_axis_tready),
        .o_limited_current     (limited_current),
        .o_was_scaled          (m_axis_tuser[0])
    );

    assign m_axis_tdata = limited_current;

endmodule

### hdl/mpl_chk.sv
`include "motor_power_limiter_top_defines.svh"

module mpl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);
    import mpl_pkg::*;

    // No result is pending right after reset.
    `MPL_ASSERT_RESET(a_out_empty_after_rst, !m_axis_tvalid)

    // A stalled result beat holds.
    `MPL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // One motor at a time: the input closes after an accepted beat.
    `MPL_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A solved current always lies within the clamp.
    `MPL_ASSERT_IMPL(a_scaled_clamped, m_axis_tvalid && m_axis_tuser[0], ($signed(m_axis_tdata) <= CURRENT_CLAMP) && ($signed(m_axis_tdata) >= -CURRENT_CLAMP))

endmodule

bind motor_power_limiter_top mpl_chk u_mpl_chk (.*);

### dv/motor_power_limiter_top_test.sv
module motor_power_limiter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpl_pkg::*;

    localparam int RUN_LIMIT = 5000000;
    localparam int HOLD_CYCLES = 3000;

    // One expected output beat.
    typedef struct {
        logic signed [15:0] current;
        bit                 scaled;
    } limit_result_t;

    // Predicts the limited current and keeps the results still owed by the block.
    class power_limit_board;
        localparam longint KT = 64'sd2195604;
        localparam longint A2 = 64'sd135240;
        localparam longint K2 = 64'sd159759;
        localparam longint C0 = 64'sd4487106952954;
        localparam longint HALF_RATIO = 64'sd136188024;
        localparam longint K2A = 64'sd77418;
        localparam longint CA = 64'sd2174409886269;
        localparam longint SA = 64'sd2081300813;

        bit [7:0]      limit_w = 8'd50;
        bit            cap_en = 1'b0;
        longint        open_sum = 0;
        longint        closed_total = 0;
        int            slot = 0;
        limit_result_t owed[$];
        int            errors = 0;

        function void report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endfunction

        function void set_reg(bit [CFG_ADDR_W-1:0] idx, bit [7:0] val);
            if (idx == CFG_CHASSIS_LIMIT) limit_w = val;
            else cap_en = val[0];
        endfunction

        // Arithmetic shift right, rounding half up.
        function longint round_shift(longint x, int s);
            return (x + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function void note_input(logic signed [15:0] cur_in, logic signed [15:0] spd_in,
                                 logic [12:0] cap_in, logic fault);
            longint cur, w, pw, budget, s, p, q, d, iq, iv, capv;
            limit_result_t r;
            cur = cur_in;
            w = spd_in;
            capv = cap_in;
            r.current = cur_in;
            r.scaled = 1'b0;
            pw = round_shift(KT * cur * w + K2 * w * w + A2 * cur * cur + C0, 32);
            // The window sum saturates at 32 bits; negative estimates are left out.
            if (pw >= 0) begin
                open_sum += pw;
                if (open_sum > 64'sd4294967295) open_sum = 64'sd4294967295;
            end
            slot++;
            if (slot >= MOTORS_PER_WINDOW) begin
                slot = 0;
                closed_total = open_sum;
                open_sum = 0;
            end
            if (capv > 5000) capv = 5000;
            budget = longint'(limit_w) * 256;
            if (!fault && cap_en) budget += (capv * 256 + 50) / 100;
            // Solve the quadratic for current when the window is over budget.
            if (closed_total > budget && !(pw < 0 && budget > 0)) begin
                s = 0;
                if (budget > 0) s = (pw * budget + closed_total / 2) / closed_total;
                p = round_shift(w * HALF_RATIO, 16);
                q = w * w * K2A + CA - s * SA;
                d = p * p - q;
                if (d < 0) d = 0;
                iq = (cur > 0) ? (-p + int_sqrt(d)) : (-p - int_sqrt(d));
                iv = round_shift(iq, 8);
                if (iv > 16000) iv = 16000;
                if (iv < -16000) iv = -16000;
                r.current = iv[15:0];
                r.scaled = 1'b1;
            end
            owed.push_back(r);
        endfunction

        function void check_result(logic [15:0] cur, logic scaled);
            limit_result_t e;
            if (owed.size() == 0) begin
                report($sformatf("unexpected beat current=%0d", $signed(cur)));
                return;
            end
            e = owed.pop_front();
            if (cur !== e.current)
                report($sformatf("current %0d, expected %0d",
                                 $signed(cur), e.current));
            if (scaled !== e.scaled)
                report($sformatf("scaled flag %b, expected %b", scaled, e.scaled));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    power_limit_board board = new();
    bit hold_out = 1'b0;
    int cycles = 0;

    motor_power_limiter_top dut (.*);

    always #4 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int k;
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                m_axis_tready = 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(negedge i_clk);
                hold_out = 1'b0;
            end
            k = $urandom_range(0, 99);
            if (k < 60) m_axis_tready = 1'b1;
            else if (k < 95) m_axis_tready = 1'b0;
            else begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(20, 150)) @(negedge i_clk);
            end
        end
    end

    function int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // Offers one beat, lowering valid only for a gap, and waits for acceptance.
    task automatic send_motor(logic signed [15:0] cur, logic signed [15:0] spd,
                              logic [12:0] cap, logic fault, int gap);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata = {2'b00, fault, cap, spd, cur};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input(cur, spd, cap, fault);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        board.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (board.owed.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic random_motor(bit no_gap);
        logic signed [15:0] cur, spd;
        int k;
        k = $urandom_range(0, 9);
        cur = 16'(int'($urandom_range(0, 32768)) - 16384);
        if (k < 6) spd = 16'($urandom);
        else if (k < 8) spd = 16'(int'($urandom_range(0, 2000)) - 1000);
        else spd = (k == 8) ? 16'sh7fff : 16'sh8000;
        if ($urandom_range(0, 9) == 0) cur = (k < 5) ? 16'sd16384 : -16'sd16384;
        send_motor(cur, spd, 13'($urandom_range(0, 8191)), $urandom_range(0, 3) == 0,
                   no_gap ? 0 : pick_gap());
    endtask

    initial begin
        int ph, n;
        logic [7:0] lims[6];
        bit ens[6];
        lims = '{8'd50, 8'd0, 8'd255, 8'd10, 8'd0, 8'd120};
        ens = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, cap above range, fault, negative power.
        write_reg(CFG_SUPERCAP_EN, 8'd1);
        send_motor(16'sd0, 16'sd0, 13'd0, 1'b0, 0);
        send_motor(16'sd16384, 16'sh7fff, 13'd5000, 1'b0, 0);
        send_motor(-16'sd16384, 16'sh8000, 13'd8191, 1'b0, 0);
        send_motor(16'sd16384, 16'sh8000, 13'd8191, 1'b1, 0);
        send_motor(-16'sd16384, 16'sh7fff, 13'd0, 1'b0, 2);
        send_motor(16'sd16384, 16'sh7fff, 13'd4999, 1'b1, 0);
        send_motor(16'sd1, 16'sd1, 13'd5001, 1'b0, 0);
        send_motor(-16'sd1, -16'sd1, 13'd100, 1'b0, 0);
        send_motor(16'sd16384, -16'sd30000, 13'd5000, 1'b0, 0);
        send_motor(-16'sd16384, 16'sd30000, 13'd2500, 1'b1, 0);
        send_motor(16'sd8000, 16'sd9000, 13'd0, 1'b0, 0);
        send_motor(-16'sd8000, -16'sd9000, 13'h1fff, 1'b0, 0);
        drain();
        // Zero budget: solved current with no power to spend.
        write_reg(CFG_CHASSIS_LIMIT, 8'd0);
        write_reg(CFG_SUPERCAP_EN, 8'd0);
        for (n = 0; n < 8; n++)
            send_motor((n[0]) ? 16'sd16384 : -16'sd16384, 16'sd20000, 13'd5000, 1'b0, 0);
        drain();

        // Random phases over several register settings.
        for (ph = 0; ph < 6; ph++) begin
            write_reg(CFG_CHASSIS_LIMIT, lims[ph]);
            write_reg(CFG_SUPERCAP_EN, {7'd0, ens[ph]});
            for (n = 0; n < 330; n++) begin
                // Back-to-back offers while the receiver holds off fills the block.
                if (ph == 2 && n == 20) hold_out = 1'b1;
                random_motor(ph == 2 && n >= 20 && n < 40);
            end
            drain();
        end

        repeat (200) @(negedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
